### hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and beat types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	// arena geometry
	localparam int ARENA_BYTES   = 4096;
	localparam int HEADER_BYTES  = 16;
	localparam int MIN_CAP_RESET = 24;

	// fixed field widths
	localparam int FIELD_W = 12;
	localparam int CFG_W   = 8;

	// derived widths
	localparam int ADDR_W = $clog2(ARENA_BYTES);
	localparam int CAP_W  = ADDR_W;
	localparam int HDR_W  = CAP_W + 1;
	localparam int CALC_W = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 3;

	// header of the single free block that spans the arena after reset
	localparam logic [HDR_W-1:0] HDR_RESET = {1'b1, CAP_W'(ARENA_BYTES - HEADER_BYTES)};

	// operations
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status
	localparam logic ST_DONE  = 1'b0;
	localparam logic ST_NOFIT = 1'b1;

	// header write kinds
	localparam logic [2:0] WR_NONE = 3'd0;
	localparam logic [2:0] WR_FREE = 3'd1;
	localparam logic [2:0] WR_USED = 3'd2;
	localparam logic [2:0] WR_TAIL = 3'd3;
	localparam logic [2:0] WR_TAKE = 3'd4;

	// result kinds
	localparam logic [1:0] FIN_EMPTY = 2'd0;
	localparam logic [1:0] FIN_OK    = 2'd1;
	localparam logic [1:0] FIN_FAIL  = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [FIELD_W-1:0] request_bytes;
		logic [FIELD_W-1:0] block_address;
	} ffha_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] payload_address;
		logic               status;
	} ffha_rsp_t;

	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic       peek;
		logic       absorb;
		logic [2:0] wr;
		logic       fin;
		logic [1:0] fin_kind;
	} ffha_cmd_t;

	typedef struct packed {
		logic op_free;
		logic skip;
		logic hdr_free;
		logic hit;
		logic past;
		logic nxt_end;
		logic rd_free;
		logic fits;
		logic split;
		logic tail_ok;
	} ffha_stat_t;

endpackage

### hw/rtl/ffha_dpath.sv
// ----------------------------------------------------------------------------
// ffha_dpath
// Header memory, walk pointer, capacity accumulator and result register.
// ----------------------------------------------------------------------------
module ffha_dpath import ffha_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ffha_req_t          request,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_data,
	input  ffha_cmd_t          cmd,
	output ffha_stat_t         stat,
	output logic               done,
	output ffha_rsp_t          result
);

	logic [CFG_W-1:0]   min_cap_q;
	logic               op_q;
	logic               skip_q;
	logic [FIELD_W-1:0] need_q;
	logic [CALC_W-1:0]  target_q;
	logic [ADDR_W-1:0]  h_q;
	logic [CAP_W-1:0]   cap_q;
	logic               free_q;

	logic [HDR_W-1:0]   mem [ARENA_BYTES];
	logic [HDR_W-1:0]   rd_data_q;
	logic               rd_zero_q;
	logic               hdr0_wr_q;
	logic               done_q;
	ffha_rsp_t          result_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [HDR_W-1:0]   wr_data;
	logic [HDR_W-1:0]   rd_hdr;
	logic [CAP_W-1:0]   rd_cap;

	logic [FIELD_W-1:0] min_ext;
	logic [FIELD_W-1:0] need_in;
	logic [CALC_W-1:0]  h_ext;
	logic [CALC_W-1:0]  nxt;
	logic [CALC_W-1:0]  tail;
	logic [CALC_W-1:0]  payload;
	logic [CAP_W-1:0]   tail_cap;
	logic [CAP_W-1:0]   merged_cap;

	// entry 0 reads as the reset header until first written
	assign rd_hdr = rd_zero_q ? HDR_RESET : rd_data_q;
	assign rd_cap = rd_hdr[CAP_W-1:0];

	assign min_ext    = FIELD_W'(min_cap_q);
	assign need_in    = (request.request_bytes > min_ext) ? request.request_bytes : min_ext;
	assign h_ext      = CALC_W'(h_q);
	assign nxt        = h_ext + CALC_W'(HEADER_BYTES) + CALC_W'(cap_q);
	assign tail       = h_ext + CALC_W'(HEADER_BYTES) + CALC_W'(need_q);
	assign payload    = h_ext + CALC_W'(HEADER_BYTES);
	assign tail_cap   = CAP_W'(CALC_W'(cap_q) - CALC_W'(need_q) - CALC_W'(HEADER_BYTES));
	assign merged_cap = CAP_W'(CALC_W'(cap_q) + CALC_W'(HEADER_BYTES) + CALC_W'(rd_cap));

	always_comb begin
		stat.op_free  = (op_q == OP_FREE);
		stat.skip     = skip_q;
		stat.hdr_free = free_q;
		stat.hit      = (h_ext == target_q);
		stat.past     = (h_ext > target_q);
		stat.nxt_end  = (nxt >= CALC_W'(ARENA_BYTES));
		stat.rd_free  = rd_hdr[HDR_W-1];
		stat.fits     = (CALC_W'(cap_q) >= CALC_W'(need_q));
		stat.split    = (CALC_W'(need_q) + CALC_W'(HEADER_BYTES) + CALC_W'(min_cap_q))
			<= CALC_W'(cap_q);
		stat.tail_ok  = (tail < CALC_W'(ARENA_BYTES));
	end

	// memory port selection
	always_comb begin
		rd_en   = cmd.init | cmd.step | cmd.peek;
		rd_addr = cmd.init ? '0 : nxt[ADDR_W-1:0];
		wr_en   = 1'b1;
		wr_addr = h_q;
		wr_data = {1'b1, cap_q};
		case (cmd.wr)
			WR_NONE: begin
				wr_en = 1'b0;
			end
			WR_FREE: begin
				wr_data = {1'b1, cap_q};
			end
			WR_USED: begin
				wr_data = {1'b0, cap_q};
			end
			WR_TAIL: begin
				wr_addr = tail[ADDR_W-1:0];
				wr_data = {1'b1, tail_cap};
			end
			WR_TAKE: begin
				wr_data = {1'b0, CAP_W'(need_q)};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_wr_q <= 1'b0;
			rd_zero_q <= 1'b0;
			min_cap_q <= CFG_W'(MIN_CAP_RESET);
			done_q    <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0) begin
				hdr0_wr_q <= 1'b1;
			end
			if (rd_en) begin
				rd_zero_q <= (rd_addr == '0) && !hdr0_wr_q;
			end
			if (cfg_we) begin
				min_cap_q <= cfg_data;
			end
			done_q <= cmd.fin;
		end
	end

	// request latch, walk pointer and accumulator
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			op_q     <= request.operation;
			need_q   <= need_in;
			skip_q   <= CALC_W'(request.block_address) < CALC_W'(HEADER_BYTES);
			target_q <= CALC_W'(request.block_address) - CALC_W'(HEADER_BYTES);
			h_q      <= '0;
		end else if (cmd.step) begin
			h_q <= nxt[ADDR_W-1:0];
		end
		if (cmd.load) begin
			cap_q  <= rd_cap;
			free_q <= rd_hdr[HDR_W-1];
		end else if (cmd.absorb) begin
			cap_q <= merged_cap;
		end
		if (cmd.fin) begin
			case (cmd.fin_kind)
				FIN_OK: begin
					result_q.payload_address <= payload[FIELD_W-1:0];
					result_q.status          <= ST_DONE;
				end
				FIN_FAIL: begin
					result_q.payload_address <= '0;
					result_q.status          <= ST_NOFIT;
				end
				default: begin
					result_q.payload_address <= '0;
					result_q.status          <= ST_DONE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the chain walk, forward merge, split and result beat.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ffha_stat_t stat,
	output logic       busy,
	output ffha_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HDR   = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_MNEXT = 3'd3;
	localparam logic [2:0] S_MRD   = 3'd4;
	localparam logic [2:0] S_MDONE = 3'd5;
	localparam logic [2:0] S_TAKE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.wr       = WR_NONE;
		cmd.fin_kind = FIN_EMPTY;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.init = 1'b1;
					state_d  = S_HDR;
				end
			end
			S_HDR: begin
				if (stat.op_free && stat.skip) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.op_free) begin
					if (stat.hit) begin
						state_d = S_MNEXT;
					end else if (stat.past || stat.nxt_end) begin
						cmd.fin = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_HDR;
					end
				end else if (stat.hdr_free) begin
					state_d = S_MNEXT;
				end else if (stat.nxt_end) begin
					cmd.fin      = 1'b1;
					cmd.fin_kind = FIN_FAIL;
					state_d      = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_HDR;
				end
			end
			S_MNEXT: begin
				if (stat.nxt_end) begin
					state_d = S_MDONE;
				end else begin
					cmd.peek = 1'b1;
					state_d  = S_MRD;
				end
			end
			S_MRD: begin
				// absorb a free neighbor, stop at a used one
				if (stat.rd_free) begin
					cmd.absorb = 1'b1;
					state_d    = S_MNEXT;
				end else begin
					state_d = S_MDONE;
				end
			end
			S_MDONE: begin
				if (stat.op_free) begin
					cmd.wr  = WR_FREE;
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else if (stat.fits) begin
					if (stat.split && stat.tail_ok) begin
						cmd.wr  = WR_TAIL;
						state_d = S_TAKE;
					end else begin
						cmd.wr       = WR_USED;
						cmd.fin      = 1'b1;
						cmd.fin_kind = FIN_OK;
						state_d      = S_IDLE;
					end
				end else begin
					// keep the merge, move on
					cmd.wr = WR_FREE;
					if (stat.nxt_end) begin
						cmd.fin      = 1'b1;
						cmd.fin_kind = FIN_FAIL;
						state_d      = S_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = S_HDR;
					end
				end
			end
			S_TAKE: begin
				cmd.wr       = WR_TAKE;
				cmd.fin      = 1'b1;
				cmd.fin_kind = FIN_OK;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### hw/rtl/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over a header memory, with split and forward coalesce.
// ----------------------------------------------------------------------------
// Raise start with a request beat while busy is low; the beat is taken at that
// edge and busy stays high until the result is out. Each request yields exactly
// one result beat on result, marked by done for a single cycle; the receiver
// cannot stall it, so it must sample done every cycle.
// An allocate returns the payload offset, or status NOFIT with address 0.
// A free always returns address 0 and status DONE.
// Each header the walk visits from offset 0 takes S_HDR and S_EVAL; each free
// block it merges adds S_MNEXT and S_MRD per neighbor absorbed, the states that
// find the end of its run and S_MDONE to write it back; a split adds S_TAKE.
// The result beat follows the final state in the next cycle. A free below the
// header size ends in S_HDR. Walk time is set by the single read port of the
// header memory. A new request may start in the cycle done is high.
// The min_block_capacity register is written on the cfg channel (cfg_valid and
// cfg_ready), ready whenever the unit is idle and start is low.
// Reset leaves one free block covering the arena and min capacity 24; no
// clearing pass is needed, so the unit is ready right after reset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit import ffha_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ffha_req_t        request,
	output logic             done,
	output ffha_rsp_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	ffha_cmd_t  cmd;
	ffha_stat_t stat;

	// hold a register write off while a request beat is being taken
	assign cfg_ready = !busy && !start;

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	ffha_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

endmodule

### tb/tb_first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit
// Self-checking bench for the first-fit heap allocator. An internal copy of the
// block chain predicts the reply of every request beat. A directed opening
// covers the corner requests. Randomized phases follow, each under its own
// minimum block capacity, and they mix allocations, frees of live blocks and
// junk frees.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	localparam int CYCLE_LIMIT   = 8_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PLAN_DEPTH    = 4;
	localparam int PHASE_BEATS   = 225;
	localparam int PHASES        = 6;
	localparam int GAP_PCT       = 11;

	typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN} act_kind_t;

	typedef struct packed {
		act_kind_t        kind;
		logic             steady;
		ffha_req_t        beat;
		logic [CFG_W-1:0] cfg;
	} plan_entry_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	ffha_req_t        request   = '0;
	logic             cfg_valid = 1'b0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	logic             cfg_ready;
	ffha_rsp_t        result;

	// shadow of the header memory and the capacity register
	int unsigned        blk_cap [ARENA_BYTES];
	bit                 blk_open [ARENA_BYTES];
	int unsigned        min_cap;

	ffha_rsp_t          reply_due [$];
	logic [FIELD_W-1:0] live_addrs [$];
	plan_entry_t        plan [$];
	bit                 steady_run = 1'b0;
	int unsigned        mismatches = 0;
	int unsigned        settle     = 0;
	int unsigned        in_flight  = 0;

	first_fit_heap_allocator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned next_header(int unsigned h);
		int unsigned n;
		n = h + HEADER_BYTES + blk_cap[h];
		return (n >= ARENA_BYTES) ? ARENA_BYTES : n;
	endfunction

	function automatic void absorb_free_followers(int unsigned h);
		int unsigned n;
		n = next_header(h);
		while (n < ARENA_BYTES && blk_open[n]) begin
			blk_cap[h] += HEADER_BYTES + blk_cap[n];
			n = next_header(h);
		end
	endfunction

	function automatic ffha_rsp_t first_fit_step(ffha_req_t beat);
		ffha_rsp_t   r;
		int unsigned want;
		int unsigned h;
		int unsigned tail;
		int unsigned target;
		bit          settled;
		r.payload_address = '0;
		r.status = ST_DONE;
		h = 0;
		settled = 1'b0;
		if (beat.operation == OP_ALLOC) begin
			want = (beat.request_bytes > min_cap) ? beat.request_bytes : min_cap;
			r.status = ST_NOFIT;
			while (!settled && h < ARENA_BYTES) begin
				if (blk_open[h]) begin
					absorb_free_followers(h);
					if (blk_cap[h] >= want) begin
						// split only when the tail can hold a header and a minimum payload
						tail = h + HEADER_BYTES + want;
						if (want + HEADER_BYTES + min_cap <= blk_cap[h] && tail < ARENA_BYTES) begin
							blk_cap[tail] = blk_cap[h] - want - HEADER_BYTES;
							blk_open[tail] = 1'b1;
							blk_cap[h] = want;
						end
						blk_open[h] = 1'b0;
						r.status = ST_DONE;
						r.payload_address = FIELD_W'(h + HEADER_BYTES);
						live_addrs.push_back(r.payload_address);
						settled = 1'b1;
					end
				end
				if (!settled)
					h = next_header(h);
			end
		end else if (beat.block_address >= HEADER_BYTES) begin
			target = beat.block_address - HEADER_BYTES;
			// addresses off the chain fall through untouched
			while (!settled && h <= target) begin
				if (h == target) begin
					blk_open[h] = 1'b1;
					absorb_free_followers(h);
					settled = 1'b1;
				end else begin
					h = next_header(h);
				end
			end
		end
		return r;
	endfunction

	// driver: one beat or one register write at a time, fed from the plan
	always @(posedge clk) begin : driver
		logic hold_start;
		logic hold_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			hold_start = start;
			hold_cfg = cfg_valid;
			if (done)
				in_flight--;
			if (start && !busy) begin
				reply_due.push_back(first_fit_step(request));
				in_flight++;
				hold_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				min_cap = cfg_data;
				hold_cfg = 1'b0;
			end
			if (!hold_start && !hold_cfg && plan.size() != 0) begin
				case (plan[0].kind)
				ACT_REQ: begin
					if (plan[0].steady || $urandom_range(99) >= GAP_PCT) begin
						request <= plan[0].beat;
						hold_start = 1'b1;
						void'(plan.pop_front());
					end
				end
				ACT_CFG: begin
					cfg_data <= plan[0].cfg;
					hold_cfg = 1'b1;
					void'(plan.pop_front());
				end
				default: begin
					// hold until every reply is back, then a few quiet cycles
					if (in_flight != 0) begin
						settle = 0;
					end else if (settle == SETTLE_CYCLES) begin
						settle = 0;
						void'(plan.pop_front());
					end else begin
						settle++;
					end
				end
				endcase
			end
			start <= hold_start;
			cfg_valid <= hold_cfg;
		end
	end

	always @(posedge clk) begin : monitor
		ffha_rsp_t want;
		if (arst_n && done) begin
			if (reply_due.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual addr %0d status %0d",
					$time, result.payload_address, result.status);
				mismatches++;
			end else begin
				want = reply_due.pop_front();
				if (result.payload_address !== want.payload_address) begin
					$display("%0t: payload_address expected %0d actual %0d",
						$time, want.payload_address, result.payload_address);
					mismatches++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result.status);
					mismatches++;
				end
			end
		end
	end

	task automatic queue_item(input act_kind_t kind, input logic op,
		input int unsigned bytes, input int unsigned addr);
		plan_entry_t e;
		@(negedge clk);
		while (plan.size() >= PLAN_DEPTH)
			@(negedge clk);
		e.kind = kind;
		e.steady = steady_run;
		e.beat.operation = op;
		e.beat.request_bytes = FIELD_W'(bytes);
		e.beat.block_address = FIELD_W'(addr);
		e.cfg = CFG_W'(bytes);
		plan.push_back(e);
	endtask

	task automatic drain_replies();
		queue_item(ACT_DRAIN, OP_ALLOC, 0, 0);
		while (plan.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0]   phase_cap [PHASES];
		int unsigned        counted;
		int unsigned        roll;
		int unsigned        pick;
		int unsigned        bytes;
		logic [FIELD_W-1:0] addr;
		for (int i = 0; i < ARENA_BYTES; i++) begin
			blk_cap[i] = 0;
			blk_open[i] = 1'b0;
		end
		blk_cap[0] = ARENA_BYTES - HEADER_BYTES;
		blk_open[0] = 1'b1;
		min_cap = MIN_CAP_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening under the reset capacity
		queue_item(ACT_REQ, OP_ALLOC, 0, 0);
		queue_item(ACT_REQ, OP_ALLOC, 1, 0);
		queue_item(ACT_REQ, OP_ALLOC, 100, 0);
		queue_item(ACT_REQ, OP_ALLOC, 4095, 4095);
		queue_item(ACT_REQ, OP_FREE, 4095, 0);
		queue_item(ACT_REQ, OP_FREE, 0, 5);
		queue_item(ACT_REQ, OP_FREE, 0, 17);
		queue_item(ACT_REQ, OP_FREE, 0, 4095);
		queue_item(ACT_REQ, OP_FREE, 0, 16);
		queue_item(ACT_REQ, OP_FREE, 0, 16);
		queue_item(ACT_REQ, OP_FREE, 0, 56);
		queue_item(ACT_REQ, OP_FREE, 0, 96);
		queue_item(ACT_REQ, OP_ALLOC, 4080, 0);
		queue_item(ACT_REQ, OP_FREE, 0, 16);
		queue_item(ACT_REQ, OP_ALLOC, 4064, 0);
		queue_item(ACT_REQ, OP_FREE, 0, 16);
		queue_item(ACT_REQ, OP_ALLOC, 4040, 0);
		queue_item(ACT_REQ, OP_ALLOC, 0, 0);
		queue_item(ACT_REQ, OP_FREE, 0, 16);
		queue_item(ACT_REQ, OP_ALLOC, 4041, 0);
		queue_item(ACT_REQ, OP_FREE, 0, 16);
		drain_replies();
		live_addrs.delete();

		phase_cap = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd40, 8'd24};
		phase_cap[3] = CFG_W'($urandom_range(2, 254));
		for (int p = 0; p < PHASES; p++) begin
			drain_replies();
			queue_item(ACT_CFG, OP_ALLOC, phase_cap[p], 0);
			steady_run = (p == 2);
			counted = 0;
			while (counted < PHASE_BEATS) begin
				roll = $urandom_range(99);
				if (roll < 12) begin
					// junk free: zero, inside a header, anywhere, or just off a live block
					case ($urandom_range(3))
					0: addr = '0;
					1: addr = FIELD_W'($urandom_range(HEADER_BYTES - 1));
					2: addr = FIELD_W'($urandom_range(4095));
					default: addr = (live_addrs.size() != 0) ?
						live_addrs[$urandom_range(live_addrs.size() - 1)] +
						FIELD_W'($urandom_range(1, 7)) : FIELD_W'($urandom_range(4095));
					endcase
					queue_item(ACT_REQ, OP_FREE, $urandom_range(4095), addr);
					counted++;
				end else if (live_addrs.size() != 0 &&
					roll < ((live_addrs.size() > 40) ? 80 : 48)) begin
					pick = $urandom_range(live_addrs.size() - 1);
					addr = live_addrs[pick];
					live_addrs.delete(pick);
					queue_item(ACT_REQ, OP_FREE, $urandom_range(4095), addr);
					counted++;
				end else begin
					roll = $urandom_range(99);
					if (roll < 70)
						bytes = $urandom_range(64);
					else if (roll < 95)
						bytes = $urandom_range(400);
					else
						bytes = $urandom_range(4095);
					queue_item(ACT_REQ, OP_ALLOC, bytes, $urandom_range(4095));
					counted++;
				end
			end
			if (p == 3) begin
				// release every live block so later walks coalesce long runs
				drain_replies();
				while (live_addrs.size() != 0) begin
					pick = $urandom_range(live_addrs.size() - 1);
					addr = live_addrs[pick];
					live_addrs.delete(pick);
					queue_item(ACT_REQ, OP_FREE, $urandom_range(4095), addr);
				end
			end
		end
		steady_run = 1'b0;
		drain_replies();
		while (start || reply_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES * 4) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_dpath.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_unit.sv
tb/tb_first_fit_heap_allocator_unit.sv
